@@ rtl/core/rolling_window_aggregate_top_assert.svh @@
// Assertion macros used by the RTL of the rolling window block.
`ifndef ROLLING_WINDOW_AGGREGATE_TOP_ASSERT_SVH
`define ROLLING_WINDOW_AGGREGATE_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RWA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define RWA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/rwa_pkg.sv @@
package rwa_pkg;

  // Aggregate selection codes
  localparam logic [2:0] MODE_SUM  = 3'd0;
  localparam logic [2:0] MODE_MUL  = 3'd1;
  localparam logic [2:0] MODE_MEAN = 3'd2;
  localparam logic [2:0] MODE_STD  = 3'd3;
  localparam logic [2:0] MODE_MIN  = 3'd4;
  localparam logic [2:0] MODE_MAX  = 3'd5;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WLEN = 2'd1;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               start_req;
  } in_t;

  typedef struct packed {
    logic               valid_res;
    logic signed [63:0] value;
  } res_t;

endpackage

@@ rtl/core/rolling_window_aggregate_top.sv @@
// Sliding-window statistics over signed 16-bit samples. Each accepted beat is
// written into a ring of WINDOW_MAX entries and yields one result beat: sum,
// saturated product, mean or standard deviation (8 fraction bits, rounded
// down), minimum or maximum over the newest window_length samples. in_ready
// is low while one sample is in work. A sample whose window is not yet full,
// or whose mode is unknown, skips the window walk and yields valid_res low.
// Otherwise the window is walked one entry at a time through the single ring
// read port and the shared multiplier, with a read state and an accumulate
// state per entry and, for product, an upper-half state, since its 64-bit
// running value is multiplied one 32-bit half at a time. Sum, minimum,
// maximum and product then finish; mean runs a 64-step divider, and
// deviation runs three multiplies, the divider, then a 32-step square root.
// A finished result waits in the output register while the next sample is
// accepted. Configuration writes are taken in any cycle.
`include "rolling_window_aggregate_top_assert.svh"

module rolling_window_aggregate_top #(
  parameter int WINDOW_MAX = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  rwa_pkg::in_t                      in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output rwa_pkg::res_t                     out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rwa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rwa_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int LG    = $clog2(WINDOW_MAX);
  localparam int SLOT_W = LG;
  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;
  localparam int MAG_W = 16 + LG;
  localparam int SUM_W = MAG_W + 1;
  localparam int S2_W  = 31 + LG;
  localparam int DVS_W = 2 * LG + 1;
  localparam int A_W   = (S2_W > 32) ? S2_W : 32;
  localparam int PRD_W = A_W + MAG_W;

  typedef enum logic [11:0] {
    ST_IDLE = 12'b000000000001,
    ST_RD   = 12'b000000000010,
    ST_ACC  = 12'b000000000100,
    ST_POST = 12'b000000001000,
    ST_M1   = 12'b000000010000,
    ST_M2   = 12'b000000100000,
    ST_M3   = 12'b000001000000,
    ST_DIV  = 12'b000010000000,
    ST_DFIN = 12'b000100000000,
    ST_SQRT = 12'b001000000000,
    ST_FIN  = 12'b010000000000,
    ST_MHI  = 12'b100000000000
  } state_t;

  state_t state;

  // Configuration and bookkeeping
  logic [2:0]         mode;
  logic [4:0]         wlen;
  logic [SLOT_W-1:0]  write_slot;
  logic [CNT_W-1:0]   fill_count;

  // Per-sample work registers
  logic [2:0]         cur_mode;
  logic [CNT_W-1:0]   n;
  logic [CNT_W-1:0]   cnt;
  logic [SLOT_W-1:0]  rd_addr;
  logic signed [15:0] rd_data;
  logic signed [15:0] ring [WINDOW_MAX];
  logic signed [SUM_W-1:0] s;
  logic [S2_W-1:0]    s2;
  logic [63:0]        mag;
  logic [PRD_W-1:0]   plo;
  logic               sat;
  logic               neg;
  logic               zero;
  logic signed [15:0] best;
  logic [63:0]        t1;
  logic [63:0]        dvd;
  logic [DVS_W-1:0]   dvs;
  logic [DVS_W-1:0]   rem;
  logic [63:0]        root;
  logic [63:0]        sq_bit;
  logic [5:0]         step;
  logic               res_ok;
  logic signed [63:0] res_val;

  logic               in_acc;
  assign in_ready  = (state == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Effective window length and fill count for the incoming beat
  logic [CMP_W-1:0] wl_ext;
  logic [CNT_W-1:0] n_new;
  logic [CNT_W-1:0] fill_base;
  logic [CNT_W-1:0] fill_new;
  always_comb begin
    wl_ext = CMP_W'(wlen);
    if (wlen == 5'd0) begin
      n_new = CNT_W'(1);
    end else if (wl_ext > CMP_W'(WINDOW_MAX)) begin
      n_new = CNT_W'(WINDOW_MAX);
    end else begin
      n_new = CNT_W'(wl_ext);
    end
    fill_base = in_data.start_req ? '0 : fill_count;
    fill_new  = (fill_base < CNT_W'(WINDOW_MAX)) ? CNT_W'(fill_base + 1'b1) : fill_base;
  end

  // Current entry and shared multiplier
  logic signed [16:0] xe;
  logic [16:0]        axe;
  logic [MAG_W-1:0]   ax;
  logic [MAG_W-1:0]   abs_s;
  logic [A_W-1:0]     mul_a;
  logic [MAG_W-1:0]   mul_b;
  logic [PRD_W-1:0]   prod;
  logic [64:0]        mul_sum;
  logic               mul_ovf;
  always_comb begin
    xe    = {rd_data[15], rd_data};
    axe   = rd_data[15] ? 17'(-xe) : 17'(xe);
    ax    = MAG_W'(axe);
    abs_s = s[SUM_W-1] ? MAG_W'(-s) : MAG_W'(s);
    mul_a = A_W'(ax);
    mul_b = ax;
    case (state)
      ST_ACC: begin
        mul_a = (cur_mode == rwa_pkg::MODE_MUL) ? A_W'(mag[31:0]) : A_W'(ax);
        mul_b = ax;
      end
      ST_MHI: begin
        mul_a = A_W'(mag[63:32]);
        mul_b = ax;
      end
      ST_M1: begin
        mul_a = A_W'(s2);
        mul_b = MAG_W'(n);
      end
      ST_M2: begin
        mul_a = A_W'(abs_s);
        mul_b = abs_s;
      end
      ST_M3: begin
        mul_a = A_W'(n);
        mul_b = MAG_W'(n);
      end
      default: begin
        mul_a = A_W'(ax);
        mul_b = ax;
      end
    endcase
    prod = PRD_W'(mul_a) * PRD_W'(mul_b);
    // combine the upper half product with the stored lower half
    mul_sum = {1'b0, prod[31:0], 32'd0} + 65'(plo);
    mul_ovf = (|prod[PRD_W-1:32]) | mul_sum[64];
  end

  // Divider step and square-root step
  logic [DVS_W:0]  rs;
  logic            ge;
  logic [63:0]     sq_t;
  logic            sq_ge;
  logic [63:0]     root_next;
  always_comb begin
    rs        = {rem, dvd[63]};
    ge        = (rs >= {1'b0, dvs});
    sq_t      = root + sq_bit;
    sq_ge     = (dvd >= sq_t);
    root_next = sq_ge ? ((root >> 1) + sq_bit) : (root >> 1);
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= rwa_pkg::MODE_SUM;
      wlen <= 5'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rwa_pkg::CFG_MODE: mode <= cfg_data[2:0];
        rwa_pkg::CFG_WLEN: wlen <= cfg_data;
        default: ;
      endcase
    end
  end

  // Ring memory: write on accept, registered read
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ring[write_slot] <= in_data.sample;
    end
    rd_data <= ring[rd_addr];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      write_slot <= '0;
      fill_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != ST_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            write_slot <= (write_slot == SLOT_W'(WINDOW_MAX - 1)) ? '0
                          : SLOT_W'(write_slot + 1'b1);
            fill_count <= fill_new;
            cur_mode   <= mode;
            n          <= n_new;
            cnt        <= '0;
            rd_addr    <= write_slot;
            s          <= '0;
            s2         <= '0;
            mag        <= 64'd1;
            sat        <= 1'b0;
            neg        <= 1'b0;
            zero       <= 1'b0;
            res_ok     <= 1'b0;
            res_val    <= '0;
            if (fill_new < n_new || !(mode inside {rwa_pkg::MODE_SUM, rwa_pkg::MODE_MUL,
                rwa_pkg::MODE_MEAN, rwa_pkg::MODE_STD, rwa_pkg::MODE_MIN,
                rwa_pkg::MODE_MAX})) begin
              state <= ST_FIN;
            end else begin
              state <= ST_RD;
            end
          end
        end
        ST_RD: begin
          state <= ST_ACC;
        end
        ST_ACC: begin
          // fold one entry into the sum, square, sign, zero and best accumulators
          s    <= s + SUM_W'(rd_data);
          s2   <= s2 + S2_W'(prod);
          neg  <= neg ^ rd_data[15];
          zero <= zero | (rd_data == 16'sd0);
          if (cnt == '0 ||
              ((cur_mode == rwa_pkg::MODE_MIN) ? (rd_data < best) : (rd_data > best))) begin
            best <= rd_data;
          end
          cnt <= CNT_W'(cnt + 1'b1);
          if (cur_mode == rwa_pkg::MODE_MUL) begin
            // keep the lower half product for the upper half multiply
            plo   <= prod;
            state <= ST_MHI;
          end else begin
            rd_addr <= (rd_addr == '0) ? SLOT_W'(WINDOW_MAX - 1) : SLOT_W'(rd_addr - 1'b1);
            state   <= (CNT_W'(cnt + 1'b1) == n) ? ST_POST : ST_RD;
          end
        end
        ST_MHI: begin
          // finish the running product for this entry
          if (!sat) begin
            if (mul_ovf) begin
              sat <= 1'b1;
            end else begin
              mag <= mul_sum[63:0];
            end
          end
          rd_addr <= (rd_addr == '0) ? SLOT_W'(WINDOW_MAX - 1) : SLOT_W'(rd_addr - 1'b1);
          state   <= (cnt == n) ? ST_POST : ST_RD;
        end
        ST_POST: begin
          res_ok <= 1'b1;
          case (cur_mode)
            rwa_pkg::MODE_SUM: begin
              res_val <= 64'(s);
              state   <= ST_FIN;
            end
            rwa_pkg::MODE_MUL: begin
              if (zero) begin
                res_val <= '0;
              end else if (neg) begin
                res_val <= (sat || mag[63]) ? {1'b1, 63'd0} : -$signed(mag);
              end else begin
                res_val <= (sat || mag[63]) ? {1'b0, {63{1'b1}}} : $signed(mag);
              end
              state <= ST_FIN;
            end
            rwa_pkg::MODE_MEAN: begin
              dvd   <= 64'(abs_s) << 8;
              dvs   <= DVS_W'(n);
              rem   <= '0;
              step  <= '0;
              state <= ST_DIV;
            end
            rwa_pkg::MODE_STD: begin
              state <= ST_M1;
            end
            default: begin
              res_val <= 64'(best);
              state   <= ST_FIN;
            end
          endcase
        end
        ST_M1: begin
          t1    <= 64'(prod);
          state <= ST_M2;
        end
        ST_M2: begin
          dvd   <= t1 - 64'(prod);
          state <= ST_M3;
        end
        ST_M3: begin
          dvs   <= prod[DVS_W-1:0];
          dvd   <= dvd << 16;
          rem   <= '0;
          step  <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          // one restoring quotient bit per cycle
          rem   <= ge ? DVS_W'(rs - {1'b0, dvs}) : rs[DVS_W-1:0];
          dvd   <= {dvd[62:0], ge};
          step  <= 6'(step + 1'b1);
          if (step == 6'd63) begin
            state <= ST_DFIN;
          end
        end
        ST_DFIN: begin
          if (cur_mode == rwa_pkg::MODE_MEAN) begin
            res_val <= s[SUM_W-1] ? -$signed(dvd + 64'(rem != '0)) : $signed(dvd);
            state   <= ST_FIN;
          end else begin
            root   <= '0;
            sq_bit <= 64'd1 << 62;
            step   <= '0;
            state  <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          // one result bit per cycle
          if (sq_ge) begin
            dvd <= dvd - sq_t;
          end
          root   <= root_next;
          sq_bit <= sq_bit >> 2;
          step   <= 6'(step + 1'b1);
          if (step == 6'd31) begin
            res_val <= $signed(root_next);
            state   <= ST_FIN;
          end
        end
        ST_FIN: begin
          // hand off once the output register is free
          if (!out_valid || out_ready) begin
            out_valid          <= 1'b1;
            out_data.valid_res <= res_ok;
            out_data.value     <= res_val;
            state              <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `RWA_ASSERT_NXT(a_busy_after_accept, in_acc, !in_ready, "ready held high after accept")
  `RWA_ASSERT_IMP(a_fill_bound, 1'b1, fill_count <= CNT_W'(WINDOW_MAX), "fill count overran")
  `RWA_ASSERT_IMP(a_walk_bound, state == ST_ACC, cnt < n, "window walk overran")
  `RWA_ASSERT_IMP(a_sqrt_bit, state == ST_SQRT, sq_bit != 64'd0, "square root ran dry")

endmodule

@@ sim/tb_rolling_window_aggregate_top.sv @@
`timescale 1ns / 100ps

module tb_rolling_window_aggregate_top;

  // Mode codes the block does not know
  localparam logic [2:0] MODE_RSVD_LO = 3'd6;
  localparam logic [2:0] MODE_RSVD_HI = 3'd7;
  localparam int RING_DEPTH = 16;
  localparam int SETTLE_CYCLES = 200;
  localparam longint CYCLE_LIMIT = 2000000;
  localparam int HOLD_AT_BEAT = 600;
  localparam int HOLD_CYCLES = 400;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  rwa_pkg::in_t in_data;
  logic out_valid;
  logic out_ready;
  rwa_pkg::res_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [rwa_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rwa_pkg::CFG_DATA_W-1:0] cfg_data;

  rolling_window_aggregate_top dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Shadow of the block's configuration and window state
  logic [2:0] cur_mode;
  logic [4:0] cur_wlen;
  logic signed [15:0] ring [RING_DEPTH];
  logic [3:0] wslot;
  logic [4:0] fill;

  rwa_pkg::in_t sample_queue[$];
  rwa_pkg::res_t expected_results[$];
  int mismatches;
  int accepted_beats;
  bit calm;
  longint cycles;

  // Integer square root, one result bit per step
  function automatic longint unsigned int_sqrt(longint unsigned q);
    longint unsigned root;
    longint unsigned cand;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if (cand * cand <= q) root = cand;
    end
    return root;
  endfunction

  // Store the sample and compute the aggregate over the newest window
  function automatic rwa_pkg::res_t aggregate_sample(rwa_pkg::in_t item);
    rwa_pkg::res_t r;
    int n;
    logic [3:0] idx;
    logic signed [15:0] w [RING_DEPTH];
    longint s;
    longint unsigned s2;
    longint unsigned ss;
    longint unsigned d;
    longint unsigned q;
    longint sc;
    longint unsigned mag;
    longint unsigned m;
    bit sat;
    bit neg;
    bit has_zero;
    logic signed [15:0] best;
    if (item.start_req) fill = 0;
    ring[wslot] = item.sample;
    wslot = wslot + 4'd1;
    if (fill < RING_DEPTH) fill = fill + 5'd1;
    n = (cur_wlen == 0) ? 1 : (cur_wlen > RING_DEPTH) ? RING_DEPTH : cur_wlen;
    r.valid_res = 1'b0;
    r.value = '0;
    if (fill < n || cur_mode == MODE_RSVD_LO || cur_mode == MODE_RSVD_HI) return r;
    for (int i = 0; i < n; i++) begin
      idx = wslot - 4'(n) + 4'(i);
      w[i] = ring[idx];
    end
    r.valid_res = 1'b1;
    case (cur_mode)
      rwa_pkg::MODE_MUL: begin
        mag = 1;
        sat = 0;
        neg = 0;
        has_zero = 0;
        for (int i = 0; i < n; i++) begin
          if (w[i] == 0) has_zero = 1;
          else begin
            if (w[i] < 0) begin
              neg = !neg;
              m = longint'(-longint'(w[i]));
            end else begin
              m = longint'(w[i]);
            end
            if (!sat) begin
              if (mag > 64'hFFFF_FFFF_FFFF_FFFF / m) sat = 1;
              else mag = mag * m;
            end
          end
        end
        if (has_zero) r.value = 0;
        else if (neg) begin
          if (sat || mag >= 64'h8000_0000_0000_0000) r.value = 64'h8000_0000_0000_0000;
          else r.value = -$signed(mag);
        end else begin
          if (sat || mag > 64'h7FFF_FFFF_FFFF_FFFF) r.value = 64'h7FFF_FFFF_FFFF_FFFF;
          else r.value = $signed(mag);
        end
      end
      rwa_pkg::MODE_MIN, rwa_pkg::MODE_MAX: begin
        best = w[0];
        for (int i = 1; i < n; i++) begin
          if (cur_mode == rwa_pkg::MODE_MIN ? (w[i] < best) : (w[i] > best)) best = w[i];
        end
        r.value = best;
      end
      default: begin
        s = 0;
        s2 = 0;
        for (int i = 0; i < n; i++) begin
          s = s + w[i];
          s2 = s2 + longint'(longint'(w[i]) * longint'(w[i]));
        end
        if (cur_mode == rwa_pkg::MODE_SUM) r.value = s;
        else if (cur_mode == rwa_pkg::MODE_MEAN) begin
          sc = s * 256;
          // round toward minus infinity
          if (sc >= 0) r.value = sc / n;
          else r.value = -((-sc + n - 1) / n);
        end else begin
          ss = (s < 0) ? -s : s;
          d = longint'(n) * s2 - ss * ss;
          q = (d << 16) / (longint'(n) * longint'(n));
          r.value = int_sqrt(q);
        end
      end
    endcase
    return r;
  endfunction

  // Clock
  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Sender: bursts of random length separated by random gaps
  int burst_left;
  int gap_left;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data <= '0;
      burst_left <= 0;
      gap_left <= 0;
      accepted_beats <= 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.insert(expected_results.size(), aggregate_sample(in_data));
        accepted_beats <= accepted_beats + 1;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0 && !calm) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (sample_queue.size() > 0) begin
          in_data <= sample_queue.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 30);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off once the stream is well under way
  int hold_left;
  bit hold_done;
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && accepted_beats >= HOLD_AT_BEAT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: alternate ready and stall stretches of random length
  int stretch_left;
  bit rx_open;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stretch_left <= 0;
      rx_open <= 1'b1;
    end else begin
      if (stretch_left > 0) stretch_left <= stretch_left - 1;
      else begin
        rx_open <= ~rx_open;
        stretch_left <= rx_open ? $urandom_range(0, 8) : $urandom_range(0, 25);
      end
      out_ready <= (calm || rx_open) && hold_left == 0;
    end
  end

  // Compare each result beat with the oldest expectation
  rwa_pkg::res_t want;
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result beat: %0d %0d",
                                      out_data.valid_res, out_data.value);
      end else begin
        want = expected_results.pop_front();
        if (out_data.valid_res !== want.valid_res || out_data.value !== want.value) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("result mismatch: expected valid=%0d value=%0d, got valid=%0d value=%0d",
                     want.valid_res, want.value, out_data.valid_res, out_data.value);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [rwa_pkg::CFG_IDX_W-1:0] idx,
                           logic [rwa_pkg::CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == rwa_pkg::CFG_MODE) cur_mode = val[2:0];
    else cur_wlen = val;
    @(posedge clk);
  endtask

  // Wait for every queued beat to pass and the block to settle
  task automatic drain();
    while (sample_queue.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_sample(logic signed [15:0] v, logic st);
    rwa_pkg::in_t item;
    item.sample = v;
    item.start_req = st;
    sample_queue.insert(sample_queue.size(), item);
  endtask

  function automatic logic signed [15:0] random_sample();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 6)) - 3);
      2: case ($urandom_range(0, 3))
           0: return -16'sd32768;
           1: return 16'sd32767;
           2: return -16'sd1;
           default: return 16'sd0;
         endcase
      default: return 16'($signed($urandom_range(0, 600)) - 300);
    endcase
  endfunction

  initial begin
    logic [2:0] md;
    logic [4:0] wl;
    int cnt;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    cycles = 0;
    calm = 1'b0;
    cur_mode = rwa_pkg::MODE_SUM;
    cur_wlen = 5'd1;
    wslot = '0;
    fill = '0;
    foreach (ring[i]) ring[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Product over a full window: saturate high, then low, then zero
    write_reg(rwa_pkg::CFG_MODE, rwa_pkg::MODE_MUL);
    write_reg(rwa_pkg::CFG_WLEN, 5'd16);
    push_sample(16'sd32767, 1'b1);
    for (int i = 0; i < 15; i++) push_sample(16'sd32767, 1'b0);
    push_sample(-16'sd32768, 1'b0);
    push_sample(16'sd0, 1'b0);
    drain();

    // Zero length acts as one; deviation of a single sample
    write_reg(rwa_pkg::CFG_MODE, rwa_pkg::MODE_STD);
    write_reg(rwa_pkg::CFG_WLEN, 5'd0);
    push_sample(-16'sd32768, 1'b1);
    push_sample(16'sd32767, 1'b0);
    drain();

    // Unknown mode and a length past the ring
    write_reg(rwa_pkg::CFG_MODE, MODE_RSVD_HI);
    write_reg(rwa_pkg::CFG_WLEN, 5'd31);
    push_sample(16'sd5, 1'b1);
    push_sample(-16'sd7, 1'b0);
    drain();

    // Random phases over all modes and a spread of lengths
    for (int ph = 0; ph < 14; ph++) begin
      md = (ph < 8) ? 3'(ph) : 3'($urandom_range(0, 7));
      case (ph)
        0: wl = 5'd16;
        1: wl = 5'd1;
        2: wl = 5'd0;
        3: wl = 5'd31;
        default: wl = 5'($urandom_range(0, 20));
      endcase
      write_reg(rwa_pkg::CFG_MODE, md);
      write_reg(rwa_pkg::CFG_WLEN, wl);
      calm = (ph % 5 == 4);
      cnt = $urandom_range(90, 130);
      for (int i = 0; i < cnt; i++)
        push_sample(random_sample(), i == 0 || $urandom_range(0, 24) == 0);
      drain();
    end

    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
